>>> rtl/core/edh_pkg.sv
// Shared types and constants of the event deduplication history block.
package edh_pkg;

  localparam int unsigned HISTORY_DEPTH = 16;
  localparam int unsigned SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned IDX_W = $clog2(HISTORY_DEPTH + 1);

  localparam logic [15:0] HOLDOFF_RESET = 16'd300;  // five minutes of one-second ticks
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    ACT_TICK   = 2'd0,
    ACT_REPORT = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_NONE   = 2'd3
  } edh_action_e;

  typedef struct packed {
    edh_action_e action;
    logic [7:0]  event_code;
  } edh_in_t;

  typedef struct packed {
    logic        recorded;
    logic        suppressed;
    logic [15:0] event_count;
    logic [7:0]  last_code;
    logic [31:0] tick_count;
  } edh_out_t;

  // One history entry as returned by the read port.
  typedef struct packed {
    logic        vld;
    logic [7:0]  code;
    logic [31:0] time_stamp;
  } edh_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_OUT  = 3'b100
  } edh_state_e;

endpackage

>>> rtl/core/edh_history.sv
// History ring storage: code and time memory with per-entry valid flags.
module edh_history import edh_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              wr_en_i,
  input  logic [SLOT_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_code_i,
  input  logic [31:0]       wr_time_i,
  input  logic              rd_en_i,
  input  logic [SLOT_W-1:0] rd_addr_i,
  output edh_entry_t        rd_entry_o
);

  logic [7:0]              code_mem [HISTORY_DEPTH];
  logic [31:0]             time_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] vld_q;
  logic                    rd_vld_q;
  logic [7:0]              rd_code_q;
  logic [31:0]             rd_time_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      code_mem[wr_addr_i] <= wr_code_i;
      time_mem[wr_addr_i] <= wr_time_i;
    end
    if (rd_en_i) begin
      rd_code_q <= code_mem[rd_addr_i];
      rd_time_q <= time_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (clr_i) begin
        vld_q <= '0;
      end else if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_entry_o = '{vld: rd_vld_q, code: rd_code_q, time_stamp: rd_time_q};

endmodule

>>> rtl/core/edh_match.sv
// Shared compare unit: code equality and modular age test against the holdoff window.
module edh_match import edh_pkg::*; (
  input  edh_entry_t  entry_i,
  input  logic [7:0]  code_i,
  input  logic [31:0] now_i,
  input  logic [15:0] holdoff_i,
  output logic        hit_o
);

  logic [31:0] age;

  // modular difference stays correct across the counter wrap
  assign age   = now_i - entry_i.time_stamp;
  assign hit_o = entry_i.vld && (entry_i.code == code_i) && (age <= {16'd0, holdoff_i});

endmodule

>>> rtl/core/event_dedup_history_unit.sv
// Top level of the event deduplication history block.
// A tick transfer advances the 32-bit tick counter, a clear transfer empties the
// history and zeroes the event count, and a report transfer is checked against
// the HISTORY_DEPTH most recent recorded codes: a match whose age is within
// holdoff_q suppresses it, otherwise it is recorded at the ring pointer.
// Every transfer yields exactly one result. The input is stalled from an accepted
// transfer until its result is loaded into the output register. A report first
// reads the whole history, one entry per cycle through a single read port into
// one age comparator. The result waits in ST_OUT while the previous result
// still sits stalled in the output register. The output register lets a new
// transfer start while the previous result still waits downstream.
module event_dedup_history_unit import edh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  edh_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output edh_out_t    out_data_o
);

  edh_state_e        st_q, st_d;
  logic [15:0]       holdoff_q;
  logic [31:0]       iter_q, iter_d;
  logic [15:0]       cnt_q, cnt_d;
  logic [7:0]        newest_q, newest_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [7:0]        code_q, code_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic              hit_q, hit_d;
  logic              rec_q, rec_d;
  logic              sup_q, sup_d;
  logic              out_vld_q, out_vld_d;
  edh_out_t          out_q, out_d;

  logic       in_acc;
  logic       rd_en;
  logic       clr;
  logic       wr_en;
  logic       hit_now;
  logic       scan_last;
  edh_entry_t rd_entry;
  logic       match_hit;

  edh_history u_history (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clr_i      (clr),
    .wr_en_i    (wr_en),
    .wr_addr_i  (slot_q),
    .wr_code_i  (code_q),
    .wr_time_i  (iter_q),
    .rd_en_i    (rd_en),
    .rd_addr_i  (rd_idx_q[SLOT_W-1:0]),
    .rd_entry_o (rd_entry)
  );

  edh_match u_match (
    .entry_i   (rd_entry),
    .code_i    (code_q),
    .now_i     (iter_q),
    .holdoff_i (holdoff_q),
    .hit_o     (match_hit)
  );

  assign in_stall_o  = (st_q != ST_IDLE);
  assign in_acc      = in_valid_i && (st_q == ST_IDLE);
  assign rd_en       = (st_q == ST_SCAN) && (rd_idx_q != IDX_W'(HISTORY_DEPTH));
  assign hit_now     = cmp_vld_q && match_hit;
  assign scan_last   = (st_q == ST_SCAN) && (rd_idx_q == IDX_W'(HISTORY_DEPTH)) && cmp_vld_q;
  assign wr_en       = scan_last && !(hit_q || hit_now);
  assign clr         = in_acc && (in_data_i.action == ACT_CLEAR);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_comb begin
    st_d      = st_q;
    iter_d    = iter_q;
    cnt_d     = cnt_q;
    newest_d  = newest_q;
    slot_d    = slot_q;
    code_d    = code_q;
    rd_idx_d  = rd_idx_q;
    cmp_vld_d = rd_en;
    hit_d     = hit_q;
    rec_d     = rec_q;
    sup_d     = sup_q;
    out_d     = out_q;
    // drop the held result once it transfers
    out_vld_d = out_vld_q && out_stall_i;

    unique case (st_q)
      ST_IDLE: begin
        if (in_acc) begin
          rec_d    = 1'b0;
          sup_d    = 1'b0;
          hit_d    = 1'b0;
          code_d   = in_data_i.event_code;
          rd_idx_d = '0;
          st_d     = ST_OUT;
          unique case (in_data_i.action)
            ACT_TICK:   iter_d = iter_q + 32'd1;
            ACT_REPORT: st_d = ST_SCAN;
            ACT_CLEAR: begin
              cnt_d  = '0;
              slot_d = '0;
            end
            ACT_NONE:   ;
          endcase
        end
      end
      ST_SCAN: begin
        hit_d = hit_q || hit_now;
        if (rd_en) begin
          rd_idx_d = rd_idx_q + IDX_W'(1);
        end
        if (scan_last) begin
          st_d = ST_OUT;
          if (hit_q || hit_now) begin
            sup_d = 1'b1;
          end else begin
            rec_d    = 1'b1;
            newest_d = code_q;
            slot_d   = (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + SLOT_W'(1);
            cnt_d    = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + 16'd1;
          end
        end
      end
      ST_OUT: begin
        if (!out_vld_q || !out_stall_i) begin
          out_d = '{recorded: rec_q, suppressed: sup_q, event_count: cnt_q,
                    last_code: newest_q, tick_count: iter_q};
          out_vld_d = 1'b1;
          st_d      = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      holdoff_q <= HOLDOFF_RESET;
      iter_q    <= '0;
      cnt_q     <= '0;
      newest_q  <= '0;
      slot_q    <= '0;
      rd_idx_q  <= '0;
      cmp_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      rec_q     <= 1'b0;
      sup_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      iter_q    <= iter_d;
      cnt_q     <= cnt_d;
      newest_q  <= newest_d;
      slot_q    <= slot_d;
      rd_idx_q  <= rd_idx_d;
      cmp_vld_q <= cmp_vld_d;
      hit_q     <= hit_d;
      rec_q     <= rec_d;
      sup_q     <= sup_d;
      out_vld_q <= out_vld_d;
      if (cfg_we_i) begin
        holdoff_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    out_q  <= out_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_q.recorded && out_q.suppressed))
    else $error("result both recorded and suppressed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_last |=> (st_q == ST_OUT) && (rec_q != sup_q))
    else $error("scan end did not decide the report");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !cmp_vld_q)
    else $error("history read pending while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) && (cnt_q != $past(cnt_q) + 16'd1) |-> $past(clr))
    else $error("event count changed without record or clear");

endmodule
